// ===== rtl/core/qfr_pkg.sv =====
// ----------------------------------------------------------------------------
// qfr_pkg
// Shared types and constants of the quad fade and rotate pipeline.
// ----------------------------------------------------------------------------
package qfr_pkg;

	localparam int NUM_VERT   = 4;
	localparam int NUM_STAGES = 5;
	localparam int COORD_W    = 20;
	localparam int COLOR_W    = 32;
	localparam int TRIG_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_FADE_EN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPIN_EN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REF_X    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REF_Y    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_SIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_COS  = 3'd5;

	localparam logic [TRIG_W-1:0]  COS_RESET   = 16'h4000;
	localparam logic [21:0]        FADE_FULL   = 22'h200000;
	localparam logic [30:0]        FADE_ROUND  = 31'h00100000;
	localparam logic signed [39:0] ROT_ROUND   = 40'sd16384;
	localparam logic signed [24:0] COORD_MAX   = 25'sd524287;
	localparam logic signed [24:0] COORD_MIN   = -25'sd524288;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [COLOR_W-1:0]        color_t;
	typedef logic [NUM_STAGES-1:0]     adv_t;

	typedef struct packed {
		logic               fade_en;
		logic               spin_en;
		logic [COORD_W-1:0] ref_x;
		logic [COORD_W-1:0] ref_y;
		logic [TRIG_W-1:0]  rot_sin;
		logic [TRIG_W-1:0]  rot_cos;
	} cfg_t;

endpackage

// ===== rtl/core/quad_fade_and_rotate.sv =====
// ----------------------------------------------------------------------------
// quad_fade_and_rotate
// Per-quad distance alpha fade and rotation about the bounding box center.
// ----------------------------------------------------------------------------
// A quad enters on the input channel when in_valid is high and in_stall is
// low, and leaves on the output channel when out_valid is high and out_stall
// is low. Both channels use valid and stall, and each field has its own port.
// The pipeline has five register stages, and the outputs are driven from
// the last one. One quad can be taken every cycle while in_stall is low; the
// rate is set by the shared advance enables, which move every stage at once
// while the receiver takes items. When the receiver stalls, the finished quad
// holds at the outputs and the earlier stages keep filling empty slots;
// in_stall rises only when every stage holds a quad. Registers are written
// through cfg_valid, cfg_ready, cfg_index and cfg_data; cfg_ready is always
// high, and indexes past the last register are ignored. Writes are to be made
// only while the pipeline is empty, a rule on the user that the block itself
// does not enforce. Reset clears all valid bits and sets fading and spinning
// off, the reference point to zero, the sine to zero and the cosine to one.
// ----------------------------------------------------------------------------
module quad_fade_and_rotate (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [qfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [qfr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  qfr_pkg::coord_t                  in_x0,
	input  qfr_pkg::coord_t                  in_x1,
	input  qfr_pkg::coord_t                  in_x2,
	input  qfr_pkg::coord_t                  in_x3,
	input  qfr_pkg::coord_t                  in_y0,
	input  qfr_pkg::coord_t                  in_y1,
	input  qfr_pkg::coord_t                  in_y2,
	input  qfr_pkg::coord_t                  in_y3,
	input  qfr_pkg::color_t                  in_color0,
	input  qfr_pkg::color_t                  in_color1,
	input  qfr_pkg::color_t                  in_color2,
	input  qfr_pkg::color_t                  in_color3,
	output logic                             out_valid,
	input  logic                             out_stall,
	output qfr_pkg::coord_t                  out_x0,
	output qfr_pkg::coord_t                  out_x1,
	output qfr_pkg::coord_t                  out_x2,
	output qfr_pkg::coord_t                  out_x3,
	output qfr_pkg::coord_t                  out_y0,
	output qfr_pkg::coord_t                  out_y1,
	output qfr_pkg::coord_t                  out_y2,
	output qfr_pkg::coord_t                  out_y3,
	output qfr_pkg::color_t                  out_color0,
	output qfr_pkg::color_t                  out_color1,
	output qfr_pkg::color_t                  out_color2,
	output qfr_pkg::color_t                  out_color3
);
	import qfr_pkg::*;

	cfg_t   cfg_q;
	adv_t   adv;
	coord_t vx [NUM_VERT], vy [NUM_VERT];
	coord_t rx [NUM_VERT], ry [NUM_VERT];
	color_t vcol [NUM_VERT], fcol [NUM_VERT];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fade_en <= 1'b0;
			cfg_q.spin_en <= 1'b0;
			cfg_q.ref_x   <= '0;
			cfg_q.ref_y   <= '0;
			cfg_q.rot_sin <= '0;
			cfg_q.rot_cos <= COS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FADE_EN: begin
					cfg_q.fade_en <= cfg_data[0];
				end
				CFG_SPIN_EN: begin
					cfg_q.spin_en <= cfg_data[0];
				end
				CFG_REF_X: begin
					cfg_q.ref_x <= cfg_data[COORD_W-1:0];
				end
				CFG_REF_Y: begin
					cfg_q.ref_y <= cfg_data[COORD_W-1:0];
				end
				CFG_ROT_SIN: begin
					cfg_q.rot_sin <= cfg_data[TRIG_W-1:0];
				end
				CFG_ROT_COS: begin
					cfg_q.rot_cos <= cfg_data[TRIG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign vx[0] = in_x0;
	assign vx[1] = in_x1;
	assign vx[2] = in_x2;
	assign vx[3] = in_x3;
	assign vy[0] = in_y0;
	assign vy[1] = in_y1;
	assign vy[2] = in_y2;
	assign vy[3] = in_y3;
	assign vcol[0] = in_color0;
	assign vcol[1] = in_color1;
	assign vcol[2] = in_color2;
	assign vcol[3] = in_color3;

	qfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.adv       (adv)
	);

	for (genvar i = 0; i < NUM_VERT; i++) begin : g_fade
		qfr_fade u_fade (
			.clk       (clk),
			.adv       (adv),
			.cfg       (cfg_q),
			.x         (vx[i]),
			.y         (vy[i]),
			.color     (vcol[i]),
			.color_out (fcol[i])
		);
	end

	qfr_spin u_spin (
		.clk (clk),
		.adv (adv),
		.cfg (cfg_q),
		.x   (vx),
		.y   (vy),
		.ox  (rx),
		.oy  (ry)
	);

	assign out_x0 = rx[0];
	assign out_x1 = rx[1];
	assign out_x2 = rx[2];
	assign out_x3 = rx[3];
	assign out_y0 = ry[0];
	assign out_y1 = ry[1];
	assign out_y2 = ry[2];
	assign out_y3 = ry[3];
	assign out_color0 = fcol[0];
	assign out_color1 = fcol[1];
	assign out_color2 = fcol[2];
	assign out_color3 = fcol[3];

endmodule

// ===== rtl/core/qfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// qfr_ctrl
// Valid bits and per-stage advance enables of the five-stage pipeline.
// ----------------------------------------------------------------------------
module qfr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output qfr_pkg::adv_t adv
);
	import qfr_pkg::*;

	adv_t vld_q;

	always_comb begin
		adv[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || !out_stall;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_stall  = !adv[0];
	assign out_valid = vld_q[NUM_STAGES-1];

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> ((&vld_q) && out_stall))
		else $error("input stalled while the pipeline has room");

	a_free_out: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled with a free receiver");

	a_last_move: assert property (@(posedge clk) disable iff (!arst_n)
		adv[NUM_STAGES-1] |=> (vld_q[NUM_STAGES-1] == $past(vld_q[NUM_STAGES-2])))
		else $error("last stage valid bit lost or invented");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv[1] |=> vld_q[1])
		else $error("held stage dropped its item");

endmodule

// ===== rtl/core/qfr_fade.sv =====
// ----------------------------------------------------------------------------
// qfr_fade
// One vertex lane of the distance based alpha fade.
// ----------------------------------------------------------------------------
module qfr_fade (
	input  logic            clk,
	input  qfr_pkg::adv_t   adv,
	input  qfr_pkg::cfg_t   cfg,
	input  qfr_pkg::coord_t x,
	input  qfr_pkg::coord_t y,
	input  qfr_pkg::color_t color,
	output qfr_pkg::color_t color_out
);
	import qfr_pkg::*;

	logic signed [20:0] dx_s1, dy_s1;
	color_t             col_s1, col_s2, col_s3, col_s4, col_s5;
	logic [40:0]        sqx_s2, sqy_s2;
	logic [21:0]        f_s3;
	logic [29:0]        prod_s4;

	logic signed [41:0] sqx, sqy;
	logic [41:0]        sq_dist;
	logic [30:0]        rounded;

	assign sqx     = dx_s1 * dx_s1;
	assign sqy     = dy_s1 * dy_s1;
	assign sq_dist = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	assign rounded = {1'b0, prod_s4} + FADE_ROUND;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			dx_s1  <= 21'($signed(cfg.ref_x)) - 21'(x);
			dy_s1  <= 21'($signed(cfg.ref_y)) - 21'(y);
			col_s1 <= color;
		end
		if (adv[1]) begin
			sqx_s2 <= sqx[40:0];
			sqy_s2 <= sqy[40:0];
			col_s2 <= col_s1;
		end
		if (adv[2]) begin
			f_s3   <= (sq_dist > 42'(FADE_FULL)) ? FADE_FULL : sq_dist[21:0];
			col_s3 <= col_s2;
		end
		if (adv[3]) begin
			prod_s4 <= 30'(col_s3[31:24]) * 30'(f_s3);
			col_s4  <= col_s3;
		end
		if (adv[4]) begin
			col_s5 <= cfg.fade_en ? {rounded[28:21], col_s4[23:0]} : col_s4;
		end
	end

	assign color_out = col_s5;

endmodule

// ===== rtl/core/qfr_spin.sv =====
// ----------------------------------------------------------------------------
// qfr_spin
// Rotation of the quad's four vertices about its bounding box center.
// ----------------------------------------------------------------------------
module qfr_spin (
	input  logic            clk,
	input  qfr_pkg::adv_t   adv,
	input  qfr_pkg::cfg_t   cfg,
	input  qfr_pkg::coord_t x [qfr_pkg::NUM_VERT],
	input  qfr_pkg::coord_t y [qfr_pkg::NUM_VERT],
	output qfr_pkg::coord_t ox [qfr_pkg::NUM_VERT],
	output qfr_pkg::coord_t oy [qfr_pkg::NUM_VERT]
);
	import qfr_pkg::*;

	coord_t             x_s1 [NUM_VERT], y_s1 [NUM_VERT];
	coord_t             x_s2 [NUM_VERT], y_s2 [NUM_VERT];
	coord_t             x_s3 [NUM_VERT], y_s3 [NUM_VERT];
	coord_t             x_s4 [NUM_VERT], y_s4 [NUM_VERT];
	coord_t             ox_s5 [NUM_VERT], oy_s5 [NUM_VERT];
	coord_t             xmin_s1, xmax_s1, ymin_s1, ymax_s1;
	logic signed [20:0] sx_s2, sy_s2, sx_s3, sy_s3;
	logic signed [21:0] rx_s2 [NUM_VERT], ry_s2 [NUM_VERT];
	logic signed [37:0] pxc_s3 [NUM_VERT], pys_s3 [NUM_VERT];
	logic signed [37:0] pxs_s3 [NUM_VERT], pyc_s3 [NUM_VERT];
	logic signed [39:0] tx_s4 [NUM_VERT], ty_s4 [NUM_VERT];

	logic signed [TRIG_W-1:0] sin_w, cos_w;
	coord_t                   xa, xb, xc, xd, ya, yb, yc, yd;
	logic signed [39:0]       cx, cy;
	logic signed [24:0]       shx [NUM_VERT], shy [NUM_VERT];

	assign sin_w = $signed(cfg.rot_sin);
	assign cos_w = $signed(cfg.rot_cos);

	assign xa = (x[0] < x[1]) ? x[0] : x[1];
	assign xb = (x[2] < x[3]) ? x[2] : x[3];
	assign xc = (x[0] > x[1]) ? x[0] : x[1];
	assign xd = (x[2] > x[3]) ? x[2] : x[3];
	assign ya = (y[0] < y[1]) ? y[0] : y[1];
	assign yb = (y[2] < y[3]) ? y[2] : y[3];
	assign yc = (y[0] > y[1]) ? y[0] : y[1];
	assign yd = (y[2] > y[3]) ? y[2] : y[3];

	assign cx = 40'(sx_s3) <<< 14;
	assign cy = 40'(sy_s3) <<< 14;

	always_comb begin
		for (int i = 0; i < NUM_VERT; i++) begin
			shx[i] = 25'(tx_s4[i] >>> 15);
			shy[i] = 25'(ty_s4[i] >>> 15);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			x_s1    <= x;
			y_s1    <= y;
			xmin_s1 <= (xa < xb) ? xa : xb;
			xmax_s1 <= (xc > xd) ? xc : xd;
			ymin_s1 <= (ya < yb) ? ya : yb;
			ymax_s1 <= (yc > yd) ? yc : yd;
		end
		if (adv[1]) begin
			x_s2  <= x_s1;
			y_s2  <= y_s1;
			sx_s2 <= 21'(xmin_s1) + 21'(xmax_s1);
			sy_s2 <= 21'(ymin_s1) + 21'(ymax_s1);
			for (int i = 0; i < NUM_VERT; i++) begin
				rx_s2[i] <= (22'(x_s1[i]) <<< 1) - (22'(xmin_s1) + 22'(xmax_s1));
				ry_s2[i] <= (22'(y_s1[i]) <<< 1) - (22'(ymin_s1) + 22'(ymax_s1));
			end
		end
		if (adv[2]) begin
			x_s3  <= x_s2;
			y_s3  <= y_s2;
			sx_s3 <= sx_s2;
			sy_s3 <= sy_s2;
			for (int i = 0; i < NUM_VERT; i++) begin
				pxc_s3[i] <= 38'(rx_s2[i]) * 38'(cos_w);
				pys_s3[i] <= 38'(ry_s2[i]) * 38'(sin_w);
				pxs_s3[i] <= 38'(rx_s2[i]) * 38'(sin_w);
				pyc_s3[i] <= 38'(ry_s2[i]) * 38'(cos_w);
			end
		end
		if (adv[3]) begin
			x_s4 <= x_s3;
			y_s4 <= y_s3;
			for (int i = 0; i < NUM_VERT; i++) begin
				tx_s4[i] <= cx + 40'(pxc_s3[i]) - 40'(pys_s3[i]) + ROT_ROUND;
				ty_s4[i] <= cy + 40'(pxs_s3[i]) + 40'(pyc_s3[i]) + ROT_ROUND;
			end
		end
		if (adv[4]) begin
			for (int i = 0; i < NUM_VERT; i++) begin
				if (!cfg.spin_en) begin
					ox_s5[i] <= x_s4[i];
					oy_s5[i] <= y_s4[i];
				end else begin
					ox_s5[i] <= (shx[i] > COORD_MAX) ? COORD_MAX[COORD_W-1:0] :
						(shx[i] < COORD_MIN) ? COORD_MIN[COORD_W-1:0] :
						shx[i][COORD_W-1:0];
					oy_s5[i] <= (shy[i] > COORD_MAX) ? COORD_MAX[COORD_W-1:0] :
						(shy[i] < COORD_MIN) ? COORD_MIN[COORD_W-1:0] :
						shy[i][COORD_W-1:0];
				end
			end
		end
	end

	assign ox = ox_s5;
	assign oy = oy_s5;

endmodule
